// ----- sv/srrw_pkg.sv -----
// Package for the selective-repeat reorder window.
// Holds field widths, packet status codes and result kind codes; no dependencies.
package srrw_pkg;

  // Field widths of the descriptor and result channels
  localparam int SEQ_W    = 32;
  localparam int LEN_W    = 11;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int WIN_W    = 5;

  // Window register value after reset
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  // Packet status codes
  localparam logic [STATUS_W-1:0] STATUS_DATA    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CORRUPT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_END     = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

endpackage

// ----- sv/srrw_ifs.sv -----
// Valid/ready channel interfaces for packet descriptors and window results.
// Depends on srrw_pkg for field widths.

interface srrw_in_if;
  logic                          valid;
  logic                          ready;
  logic [srrw_pkg::SEQ_W-1:0]    packet_seq;
  logic [srrw_pkg::LEN_W-1:0]    payload_length;
  logic [srrw_pkg::TAG_W-1:0]    payload_tag;
  logic [srrw_pkg::STATUS_W-1:0] packet_status;

  modport source (
    output valid, packet_seq, payload_length, payload_tag, packet_status,
    input  ready
  );
  modport sink (
    input  valid, packet_seq, payload_length, payload_tag, packet_status,
    output ready
  );
endinterface

interface srrw_out_if;
  logic                        valid;
  logic                        ready;
  logic [srrw_pkg::KIND_W-1:0] result_kind;
  logic [srrw_pkg::SEQ_W-1:0]  seq_or_ack;
  logic [srrw_pkg::LEN_W-1:0]  out_length;
  logic [srrw_pkg::TAG_W-1:0]  out_tag;
  logic                        last_of_run;

  modport source (
    output valid, result_kind, seq_or_ack, out_length, out_tag, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, seq_or_ack, out_length, out_tag, last_of_run,
    output ready
  );
endinterface

// ----- sv/selective_repeat_reorder_window.sv -----
// Selective-repeat reorder window: one slot compared per cycle by a shared scan unit,
// except while a delivery waits for the output register. A data packet passes through
// accept, search, store, drain (one scan pass per packet delivered plus a final pass),
// purge and ack, plus output waits. An old packet skips search and store. An end packet
// goes through accept and end. One packet in flight; ready is high only between packets.
// Synchronous reset clears all slot valid bits, expected sequence to 0, window to 16.
module selective_repeat_reorder_window #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [srrw_pkg::WIN_W-1:0]  cfg_wr_data,
  srrw_in_if.sink                     packets,
  srrw_out_if.source                  results
);

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PURGE = 3'd4;
  localparam logic [2:0] S_ACK   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;

  logic [2:0]                     state;
  logic [srrw_pkg::WIN_W-1:0]     win_cfg;
  logic [CW-1:0]                  win_eff;
  logic [WINDOW_DEPTH-1:0]        keep_mask;

  logic [srrw_pkg::SEQ_W-1:0]     cur_seq;
  logic [srrw_pkg::LEN_W-1:0]     cur_len;
  logic [srrw_pkg::TAG_W-1:0]     cur_tag;
  logic [srrw_pkg::SEQ_W-1:0]     expected;
  logic [WINDOW_DEPTH-1:0]        slot_valid;

  // Slot descriptor memory
  logic [srrw_pkg::SEQ_W-1:0]     seq_mem [WINDOW_DEPTH];
  logic [srrw_pkg::LEN_W-1:0]     len_mem [WINDOW_DEPTH];
  logic [srrw_pkg::TAG_W-1:0]     tag_mem [WINDOW_DEPTH];
  logic [srrw_pkg::SEQ_W-1:0]     rd_seq;
  logic [srrw_pkg::LEN_W-1:0]     rd_len;
  logic [srrw_pkg::TAG_W-1:0]     rd_tag;
  logic                           mem_we;
  logic                           rd_en;

  // Scan unit
  logic [CW-1:0]                  scan_idx;
  logic [IW-1:0]                  cmp_idx;
  logic                           cmp_live;
  logic                           cmp_valid;
  logic                           scan_more;
  logic                           last_cmp;
  logic                           scanning;
  logic                           scan_restart;
  logic                           match_drain;
  logic                           purge_hit;
  logic                           stall;
  logic                           held;
  logic                           free_found;
  logic [IW-1:0]                  free_idx;

  // Output register
  logic                           out_valid;
  logic                           out_free;
  logic                           out_load;
  logic [srrw_pkg::KIND_W-1:0]    out_kind;
  logic [srrw_pkg::SEQ_W-1:0]     out_seq;
  logic [srrw_pkg::LEN_W-1:0]     out_len;
  logic [srrw_pkg::TAG_W-1:0]     out_tag_q;
  logic                           out_last;

  // Clamp the window register to 1..WINDOW_DEPTH
  always_comb begin
    if (win_cfg == '0) begin
      win_eff = CW'(1);
    end else if (32'(win_cfg) > 32'(WINDOW_DEPTH)) begin
      win_eff = CW'(WINDOW_DEPTH);
    end else begin
      win_eff = CW'(win_cfg);
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      keep_mask[i] = (i < int'(win_eff));
    end
  end

  // Compare stage of the scan unit
  assign scanning    = (state == S_SRCH) || (state == S_DRAIN) || (state == S_PURGE);
  assign scan_more   = (scan_idx < win_eff);
  assign cmp_valid   = slot_valid[cmp_idx];
  assign last_cmp    = cmp_live && (CW'(cmp_idx) == win_eff - CW'(1));
  assign match_drain = cmp_live && cmp_valid && (rd_seq == expected);
  assign purge_hit   = cmp_live && cmp_valid &&
                       ((rd_seq < expected) ||
                        ({1'b0, rd_seq} >= ({1'b0, expected} + 33'(win_eff))));
  assign out_free    = !out_valid || results.ready;
  assign stall       = (state == S_DRAIN) && match_drain && !out_free;
  assign rd_en       = scanning && scan_more && !stall;
  assign mem_we      = (state == S_STORE) && !held && free_found;

  // Load the output register when a result is produced
  assign out_load    = out_free && (((state == S_DRAIN) && match_drain) ||
                                    (state == S_ACK) || (state == S_END));

  // Restart the scan from slot 0 on a new pass
  assign scan_restart = ((state == S_IDLE) && packets.valid &&
                         (packets.packet_status == srrw_pkg::STATUS_DATA)) ||
                        (state == S_STORE) ||
                        ((state == S_DRAIN) && match_drain && out_free) ||
                        ((state == S_DRAIN) && !match_drain && last_cmp);

  // Write the stored slot, read one slot per scan step
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[free_idx] <= cur_seq;
      len_mem[free_idx] <= cur_len;
      tag_mem[free_idx] <= cur_tag;
    end
    if (rd_en) begin
      rd_seq <= seq_mem[scan_idx[IW-1:0]];
      rd_len <= len_mem[scan_idx[IW-1:0]];
      rd_tag <= tag_mem[scan_idx[IW-1:0]];
    end
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= srrw_pkg::WIN_RESET;
    end else if (cfg_wr_en) begin
      win_cfg <= cfg_wr_data;
    end
  end

  // Payload registers of the output stage
  always_ff @(posedge clk) begin
    if (state == S_DRAIN && match_drain && out_free) begin
      out_kind  <= srrw_pkg::KIND_DELIVER;
      out_seq   <= rd_seq;
      out_len   <= rd_len;
      out_tag_q <= rd_tag;
      out_last  <= 1'b0;
    end else if (state == S_ACK && out_free) begin
      out_kind  <= srrw_pkg::KIND_ACK;
      out_seq   <= expected;
      out_len   <= '0;
      out_tag_q <= '0;
      out_last  <= 1'b1;
    end else if (state == S_END && out_free) begin
      out_kind  <= srrw_pkg::KIND_END;
      out_seq   <= '0;
      out_len   <= '0;
      out_tag_q <= '0;
      out_last  <= 1'b1;
    end
  end

  // Latch the accepted descriptor
  always_ff @(posedge clk) begin
    if (state == S_IDLE && packets.valid) begin
      cur_seq <= packets.packet_seq;
      cur_len <= packets.payload_length;
      cur_tag <= packets.payload_tag;
    end
  end

  // Sequencer and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      expected   <= '0;
      out_valid  <= 1'b0;
      cmp_live   <= 1'b0;
      scan_idx   <= '0;
      held       <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // Raise the output on a new result, drop it once its transfer completes
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      // Restart or advance the scan pipeline
      if (scan_restart) begin
        scan_idx <= '0;
        cmp_live <= 1'b0;
      end else if (scanning && !stall) begin
        cmp_live <= scan_more;
        cmp_idx  <= scan_idx[IW-1:0];
        if (scan_more) begin
          scan_idx <= scan_idx + CW'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (packets.valid) begin
            unique case (packets.packet_status)
              srrw_pkg::STATUS_END: begin
                slot_valid <= '0;
                expected   <= '0;
                state      <= S_END;
              end
              srrw_pkg::STATUS_DATA: begin
                slot_valid <= slot_valid & keep_mask;
                held       <= 1'b0;
                free_found <= 1'b0;
                state      <= (packets.packet_seq >= expected) ? S_SRCH : S_DRAIN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SRCH: begin
          // Look for a duplicate and the lowest free slot
          if (cmp_live) begin
            if (cmp_valid && rd_seq == cur_seq) begin
              held <= 1'b1;
            end
            if (!cmp_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
          if (last_cmp) begin
            state <= S_STORE;
          end
        end

        S_STORE: begin
          if (!held && free_found) begin
            slot_valid[free_idx] <= 1'b1;
          end
          state <= S_DRAIN;
        end

        S_DRAIN: begin
          // Deliver the expected packet and rescan from slot 0
          if (match_drain) begin
            if (out_free) begin
              slot_valid[cmp_idx] <= 1'b0;
              expected            <= expected + 32'd1;
            end
          end else if (last_cmp) begin
            state <= S_PURGE;
          end
        end

        S_PURGE: begin
          // Clear held slots outside the window
          if (purge_hit) begin
            slot_valid[cmp_idx] <= 1'b0;
          end
          if (last_cmp) begin
            state <= S_ACK;
          end
        end

        S_ACK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        S_END: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Channel outputs
  assign packets.ready       = (state == S_IDLE);
  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.seq_or_ack  = out_seq;
  assign results.out_length  = out_len;
  assign results.out_tag     = out_tag_q;
  assign results.last_of_run = out_last;

endmodule
